// ===== hdl/sha512_pkg.sv =====
// sha512_pkg: shared types, constants and round functions of the hash engine
// no dependencies
`default_nettype none
package sha512_pkg;

  localparam int WordW = 64;
  localparam int BlockWords = 16;
  localparam int Rounds = 80;
  localparam int DigestWords = 8;

  typedef struct packed {
    logic [63:0] data_word;
    logic [6:0]  valid_bits;
    logic        final_word;
  } in_word_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic        digest_last;
  } out_word_t;

  // controls from the sequencer to the round unit
  typedef struct packed {
    logic       load;   // copy chain into working vars
    logic       round;  // run one round
    logic       fold;   // add working vars into chain
    logic       init;   // restore initial hash
    logic [6:0] rnd;    // round number
  } rnd_ctl_t;

  localparam logic [63:0] PadOne = 64'h8000000000000000;

  function automatic logic [63:0] init_hash(input logic [2:0] i);
    logic [63:0] v;
    case (i)
      3'd0: v = 64'h6A09E667F3BCC908;
      3'd1: v = 64'hBB67AE8584CAA73B;
      3'd2: v = 64'h3C6EF372FE94F82B;
      3'd3: v = 64'hA54FF53A5F1D36F1;
      3'd4: v = 64'h510E527FADE682D1;
      3'd5: v = 64'h9B05688C2B3E6C1F;
      3'd6: v = 64'h1F83D9ABFB41BD6B;
      default: v = 64'h5BE0CD19137E2179;
    endcase
    return v;
  endfunction

  localparam logic [63:0] RoundK [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

endpackage
`default_nettype wire

// ===== hdl/sha512_sched.sv =====
// sha512_sched: 16-word message window that also expands the round schedule
// depends on sha512_pkg
`default_nettype none
module sha512_sched (
  input  wire logic        clk,
  input  wire logic        wr,
  input  wire logic [3:0]  wr_idx,
  input  wire logic [63:0] wr_data,
  input  wire logic        step,
  input  wire logic [6:0]  rnd,
  output logic [63:0]      w
);
  logic [63:0] win [16];
  logic [3:0]  t;
  logic [63:0] x15, x2, s0, s1, wn;

  assign t = rnd[3:0];

  // schedule expansion for rounds 16 and later
  always_comb begin
    x15 = win[t + 4'd1];
    x2  = win[t + 4'd14];
    s0  = sha512_pkg::rotr(x15, 1) ^ sha512_pkg::rotr(x15, 8) ^ (x15 >> 7);
    s1  = sha512_pkg::rotr(x2, 19) ^ sha512_pkg::rotr(x2, 61) ^ (x2 >> 6);
    wn  = s1 + win[t + 4'd9] + s0 + win[t];
    w   = (rnd >= 7'd16) ? wn : win[t];
  end

  // window update
  always_ff @(posedge clk) begin
    if (wr) begin
      win[wr_idx] <= wr_data;
    end else if (step && rnd >= 7'd16) begin
      win[t] <= wn;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/sha512_round.sv =====
// sha512_round: working variables, one shared round unit and chaining values
// depends on sha512_pkg
`default_nettype none
module sha512_round (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire sha512_pkg::rnd_ctl_t ctl,
  input  wire logic [63:0]          w,
  input  wire logic [2:0]           rd_idx,
  output logic [63:0]               rd_data
);
  logic [63:0] chain [8];
  logic [63:0] v [8];
  logic [63:0] t1, t2;

  // one compression round
  always_comb begin
    t1 = v[7] + (sha512_pkg::rotr(v[4], 14) ^ sha512_pkg::rotr(v[4], 18)
         ^ sha512_pkg::rotr(v[4], 41)) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
         + sha512_pkg::RoundK[ctl.rnd] + w;
    t2 = (sha512_pkg::rotr(v[0], 28) ^ sha512_pkg::rotr(v[0], 34)
         ^ sha512_pkg::rotr(v[0], 39)) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  assign rd_data = chain[rd_idx];

  // chaining values
  always_ff @(posedge clk) begin
    if (rst || ctl.init) begin
      for (int i = 0; i < 8; i++) chain[i] <= sha512_pkg::init_hash(3'(i));
    end else if (ctl.fold) begin
      for (int i = 0; i < 8; i++) chain[i] <= chain[i] + v[i];
    end
  end

  // working variables
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int i = 0; i < 8; i++) v[i] <= chain[i];
    end else if (ctl.round) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/sha512_hash_engine_unit.sv =====
// sha512_hash_engine_unit: SHA-512 engine top level with padding sequencer
// depends on sha512_pkg, sha512_sched, sha512_round
//
// Usage: message words enter on in_word (valid/stall); a word is taken when
// in_valid is high and in_stall low. Non-final words are placed in the block
// window as they are taken; the sixteenth word of a block starts compression,
// a load, 80 rounds at one round per cycle and a fold, during which in_stall
// is high. A final word is padded in place: the sequencer writes the one bit,
// zero words and the 64-bit length one word a cycle, compressing one or two
// blocks, then presents eight digest words on out_word, H0 first, digest_last
// on the eighth. The input stays stalled until the last digest word is taken.
// The input rate is set by the single shared round unit.
// Reset (rst, synchronous) restores the initial hash, clears the length and
// block position and drops out_valid; in_stall is high while rst is high.
// When out_stall is high the current digest word holds on out_word.
`default_nettype none
module sha512_hash_engine_unit (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire sha512_pkg::in_word_t  in_word,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output sha512_pkg::out_word_t      out_word
);
  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_LOAD, S_ROUND, S_FOLD, S_OUT
  } state_t;

  state_t      state;
  logic [3:0]  widx;
  logic [63:0] bit_length;
  logic [6:0]  rnd;
  logic        pad_mode;   // final word seen, padding in progress
  logic        one_pending;// the full-word final still needs the one word
  logic        spill;      // length does not fit, slot 15 gets a zero word
  logic        len_done;   // length word went in, digest follows the fold
  logic [2:0]  oidx;
  logic        wr;
  logic [63:0] wr_data;
  logic [63:0] w, rd_data, keep, fin_word;
  logic [6:0]  vb;
  logic        take;
  sha512_pkg::rnd_ctl_t ctl;

  assign in_stall  = rst || (state != S_IDLE);
  assign take      = in_valid && !in_stall;
  assign out_valid = (state == S_OUT);
  assign out_word.digest_word = rd_data;
  assign out_word.digest_last = (oidx == 3'd7);

  // padded final word
  always_comb begin
    vb = (in_word.valid_bits > 7'd64) ? 7'd64 : in_word.valid_bits;
    keep = (vb == 7'd0) ? 64'd0 : ~((64'd1 << (7'd64 - vb)) - 64'd1);
    fin_word = (in_word.data_word & keep) | (64'd1 << (7'd63 - vb));
  end

  // window writes
  always_comb begin
    wr = 1'b0;
    wr_data = in_word.data_word;
    if (take) begin
      wr = 1'b1;
      if (in_word.final_word && vb != 7'd64) wr_data = fin_word;
    end else if (state == S_PAD) begin
      wr = 1'b1;
      if (one_pending) wr_data = sha512_pkg::PadOne;
      else if (widx == 4'd15 && !spill) wr_data = bit_length;
      else wr_data = 64'd0;
    end
  end

  always_comb begin
    ctl.load  = (state == S_LOAD);
    ctl.round = (state == S_ROUND);
    ctl.fold  = (state == S_FOLD);
    ctl.init  = (state == S_OUT) && !out_stall && (oidx == 3'd7);
    ctl.rnd   = rnd;
  end

  sha512_sched u_sched (
    .clk(clk), .wr(wr), .wr_idx(widx), .wr_data(wr_data),
    .step(ctl.round), .rnd(rnd), .w(w)
  );

  sha512_round u_round (
    .clk(clk), .rst(rst), .ctl(ctl), .w(w), .rd_idx(oidx), .rd_data(rd_data)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      widx <= '0;
      bit_length <= '0;
      rnd <= '0;
      pad_mode <= 1'b0;
      one_pending <= 1'b0;
      spill <= 1'b0;
      len_done <= 1'b0;
      oidx <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (take) begin
            widx <= widx + 4'd1;
            if (in_word.final_word) begin
              bit_length <= bit_length + 64'(vb);
              pad_mode <= 1'b1;
              one_pending <= (vb == 7'd64);
              spill <= (vb != 7'd64) && (widx == 4'd14);
              state <= (widx == 4'd15) ? S_LOAD : S_PAD;
            end else begin
              bit_length <= bit_length + 64'd64;
              if (widx == 4'd15) state <= S_LOAD;
            end
          end
        end
        S_PAD: begin
          widx <= widx + 4'd1;
          one_pending <= 1'b0;
          // one word in slot 14 leaves no room for the length
          if (one_pending && widx == 4'd14) spill <= 1'b1;
          else if (widx == 4'd15) spill <= 1'b0;
          if (widx == 4'd15) begin
            state <= S_LOAD;
            if (!one_pending && !spill) begin
              pad_mode <= 1'b0;
              len_done <= 1'b1;
            end
          end
        end
        S_LOAD: begin
          rnd <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          rnd <= rnd + 7'd1;
          if (rnd == 7'(sha512_pkg::Rounds - 1)) state <= S_FOLD;
        end
        S_FOLD: begin
          rnd <= '0;
          if (pad_mode) begin
            state <= S_PAD;
          end else if (len_done) begin
            len_done <= 1'b0;
            state <= S_OUT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7) begin
              state <= S_IDLE;
              bit_length <= '0;
              widx <= '0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hdl/sha512_checker.sv =====
// sha512_checker: port-level assertions for the hash engine, bound to the top
// depends on sha512_pkg
`default_nettype none
module sha512_checker (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_stall,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire sha512_pkg::out_word_t out_word
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("digest word changed under stall");
  a_no_in_during_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while digest pending");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && out_word.digest_last |=> !out_valid)
    else $error("digest continued past last word");
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid && (rst || !in_stall))
    else $error("outputs active after reset");
endmodule

bind sha512_hash_engine_unit sha512_checker u_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
);
`default_nettype wire

// ===== test/testbench.sv =====
// testbench: self-checking bench for sha512_hash_engine_unit, a SHA-512 engine
// with internal padding, using its own digest predictor and random handshakes
// depends on sha512_pkg and the RTL of sha512_hash_engine_unit
`timescale 1ns / 1ps
module testbench;

  logic clk;
  logic rst;
  logic in_valid = 1'b0;
  logic in_stall;
  sha512_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sha512_pkg::out_word_t out_word;

  sha512_hash_engine_unit DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  localparam logic [63:0] KTab [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };
  localparam logic [63:0] HInit [8] = '{
    64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B, 64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
    64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F, 64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
  };

  // predictor state
  logic [63:0] hash_h [8];
  logic [63:0] blk_w [16] = '{default: '0};
  logic [3:0]  blk_pos;
  logic [63:0] msg_bits;

  sha512_pkg::in_word_t  word_q [$];
  sha512_pkg::out_word_t digest_q [$];
  int mismatches = 0;
  bit sender_done;
  bit hold_for_drain;

  function automatic logic [63:0] ror(logic [63:0] x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  // one 80-round compression of the current block into the chain
  task automatic compress_blk();
    logic [63:0] v [8];
    logic [63:0] sw [16];
    logic [63:0] t1, t2, s0, s1;
    for (int j = 0; j < 8; j++) v[j] = hash_h[j];
    for (int j = 0; j < 16; j++) sw[j] = blk_w[j];
    for (int t = 0; t < 80; t++) begin
      if (t >= 16) begin
        s0 = ror(sw[(t - 15) & 15], 1) ^ ror(sw[(t - 15) & 15], 8) ^ (sw[(t - 15) & 15] >> 7);
        s1 = ror(sw[(t - 2) & 15], 19) ^ ror(sw[(t - 2) & 15], 61) ^ (sw[(t - 2) & 15] >> 6);
        sw[t & 15] = s1 + sw[(t - 7) & 15] + s0 + sw[t & 15];
      end
      t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTab[t] + sw[t & 15];
      t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) hash_h[j] += v[j];
  endtask

  task automatic add_blk_word(logic [63:0] w);
    blk_w[blk_pos] = w;
    blk_pos = blk_pos + 4'd1;
    if (blk_pos == 0) compress_blk();
  endtask

  task automatic restart_msg();
    for (int j = 0; j < 8; j++) hash_h[j] = HInit[j];
    blk_pos = 0;
    msg_bits = 0;
  endtask

  // model one accepted word, queue the digest on a final word
  task automatic predict_digest(sha512_pkg::in_word_t w);
    int nb;
    logic [63:0] keep;
    sha512_pkg::out_word_t o;
    if (!w.final_word) begin
      msg_bits += 64;
      add_blk_word(w.data_word);
    end else begin
      nb = (w.valid_bits > 64) ? 64 : int'(w.valid_bits);
      msg_bits += nb;
      if (nb == 64) begin
        add_blk_word(w.data_word);
        add_blk_word(sha512_pkg::PadOne);
      end else begin
        keep = (nb == 0) ? 64'd0 : ~((64'd1 << (64 - nb)) - 1);
        add_blk_word((w.data_word & keep) | (64'd1 << (63 - nb)));
      end
      while (blk_pos != 14) add_blk_word(64'd0);
      add_blk_word(64'd0);
      add_blk_word(msg_bits);
      for (int k = 0; k < 8; k++) begin
        o.digest_word = hash_h[k];
        o.digest_last = (k == 7);
        digest_q = {digest_q, o};
      end
      restart_msg();
    end
  endtask

  function automatic sha512_pkg::in_word_t mk_word(logic [63:0] d, logic [6:0] vb,
                                                   logic fin);
    sha512_pkg::in_word_t w;
    w.data_word = d;
    w.valid_bits = vb;
    w.final_word = fin;
    return w;
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // one message of n full words, then a final word
  task automatic add_msg(int n, logic [6:0] vb);
    for (int i = 0; i < n; i++)
      word_q = {word_q, mk_word(rnd64(),
                                ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'd64, 1'b0)};
    word_q = {word_q, mk_word(rnd64(), vb, 1'b1)};
  endtask

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // stimulus
  initial begin
    int nwords;
    bit drained;
    rst = 1'b1;
    sender_done = 1'b0;
    hold_for_drain = 1'b0;
    // directed: empty message, extremes of valid_bits, block boundary cases
    word_q = {word_q, mk_word(64'hFFFF_FFFF_FFFF_FFFF, 7'd0, 1'b1)};
    word_q = {word_q, mk_word(64'h6162630000000000, 7'd24, 1'b1)};
    word_q = {word_q, mk_word(64'hFFFF_FFFF_FFFF_FFFF, 7'd64, 1'b1)};
    word_q = {word_q, mk_word(64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 1'b1)};
    word_q = {word_q, mk_word(64'hFFFF_FFFF_FFFF_FFFF, 7'd1, 1'b1)};
    word_q = {word_q, mk_word(64'hFFFF_FFFF_FFFF_FFFF, 7'd63, 1'b1)};
    add_msg(13, 7'd64);
    add_msg(13, 7'd63);
    add_msg(14, 7'd0);
    add_msg(15, 7'd64);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // random messages, mostly short, a few long
    nwords = 0;
    drained = 1'b0;
    while (nwords < 265) begin
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 17);
      add_msg(n, ($urandom_range(0, 2) == 0) ? 7'd64 : 7'($urandom));
      nwords += n + 1;
      if (nwords > 130 && !drained) begin
        drained = 1'b1;
        wait (word_q.size() == 0);
        hold_for_drain = 1'b1;
        wait (digest_q.size() == 0);
        hold_for_drain = 1'b0;
      end
    end
    wait (word_q.size() == 0);
    sender_done = 1'b1;
  end

  // accept flag sampled at the rising edge
  logic in_taken = 1'b0;
  always @(posedge clk) in_taken <= in_valid && !in_stall;

  // driver: presents words at the falling edge, with random gaps
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      restart_msg();
    end else begin
      if (in_taken) begin
        predict_digest(in_word);
        void'(word_q.pop_front());
        gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(0, 5);
      end
      if (in_valid && !in_taken) begin
        // hold the stalled word
      end else if (gap_left > 0 || hold_for_drain || word_q.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_word <= word_q[0];
      end
    end
  end

  // monitor: checks digest words
  logic out_taken = 1'b0;
  always @(posedge clk) begin
    out_taken <= !rst && out_valid && !out_stall;
    if (!rst && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected digest word %h last %b", out_word.digest_word,
                   out_word.digest_last);
      end else begin
        if (out_word.digest_word !== digest_q[0].digest_word ||
            out_word.digest_last !== digest_q[0].digest_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("digest mismatch: expected %h/%b got %h/%b",
                     digest_q[0].digest_word, digest_q[0].digest_last,
                     out_word.digest_word, out_word.digest_last);
        end
        void'(digest_q.pop_front());
      end
    end
  end

  // receiver stalls, drawn per accepted digest word
  int stall_left = 0;
  always @(negedge clk) begin
    if (out_taken) stall_left = $urandom_range(0, 1) ? 0 : $urandom_range(0, 5);
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // end of run
  initial begin
    wait (sender_done);
    wait (digest_q.size() == 0 && !in_valid);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
